### sv/record_framer_crc32_macros.svh
// assertion macros for the record framer
`ifndef RECORD_FRAMER_CRC32_MACROS_SVH
`define RECORD_FRAMER_CRC32_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define RFC32_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("record framer implication check failed");

// condition that must never hold outside reset
`define RFC32_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("record framer forbidden condition seen");

`endif

### sv/rfc32_pkg.sv
// types, constants and the crc step for the record framer
`timescale 1ns / 1ps

package rfc32_pkg;

    localparam int HEADER_BYTES = 44;
    localparam int LEN_BYTES    = 4;
    localparam int CRC_BYTES    = 4;
    localparam int FRAME_BITS   = 8 * (LEN_BYTES + HEADER_BYTES);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic               start_req;
        logic [63:0]        seq_number;
        logic [15:0]        record_type;
        logic [15:0]        codec_id;
        logic signed [63:0] concept_num;
        logic signed [63:0] concept_den;
        logic signed [63:0] clock_num;
        logic signed [63:0] clock_den;
        logic [23:0]        payload_length;
        logic [7:0]         data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       record_end;
    } t_out_item;

    typedef struct packed {
        logic                  is_start;
        logic                  go_crc;
        logic [FRAME_BITS-1:0] frame;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? (CRC_POLY ^ (v >> 1)) : (v >> 1);
        end
        return v;
    endfunction

endpackage

### sv/rfc32_in_if.sv
// input channel: start and payload transactions
`timescale 1ns / 1ps

interface rfc32_in_if;
    import rfc32_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/rfc32_out_if.sv
// output channel: one framed byte per transaction
`timescale 1ns / 1ps

interface rfc32_out_if;
    import rfc32_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/rfc32_front.sv
// front end: accepts transactions, tracks the open record, issues commands
`timescale 1ns / 1ps

module rfc32_front #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rfc32_in_if.sink             i_in,
    input  rfc32_pkg::t_q_status i_q_status,
    output logic                 o_push,
    output rfc32_pkg::t_cmd      o_cmd
);
    import rfc32_pkg::*;

    localparam int LW = (LENGTH_BITS < 24) ? LENGTH_BITS : 24;

    logic          r_open;
    logic [LW-1:0] r_left;
    logic          n_open;
    logic [LW-1:0] n_left;
    logic          w_accept;
    logic [LW-1:0] w_plen;
    logic [31:0]   w_body;
    logic          w_last;

    assign i_in.ready = !i_q_status.full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_plen     = i_in.data.payload_length[LW-1:0];
    assign w_body     = 32'(HEADER_BYTES) + 32'(w_plen);
    assign w_last     = (r_left == LW'(1));

    always_comb begin
        n_open       = r_open;
        n_left       = r_left;
        o_push       = 1'b0;
        o_cmd.is_start = i_in.data.start_req;
        o_cmd.go_crc   = 1'b0;
        o_cmd.frame    = {{(FRAME_BITS - 8){1'b0}}, i_in.data.data_byte};
        if (w_accept) begin
            if (i_in.data.start_req) begin
                o_push       = 1'b1;
                o_cmd.go_crc = (w_plen == '0);
                o_cmd.frame  = {i_in.data.clock_den, i_in.data.clock_num,
                                i_in.data.concept_den, i_in.data.concept_num,
                                i_in.data.codec_id, i_in.data.record_type,
                                i_in.data.seq_number, w_body};
                n_open       = (w_plen != '0);
                n_left       = w_plen;
            end else if (r_open) begin
                o_push       = 1'b1;
                o_cmd.go_crc = w_last;
                n_left       = r_left - LW'(1);
                if (w_last) begin
                    n_open = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= '0;
        end else begin
            r_open <= n_open;
            r_left <= n_left;
        end
    end

endmodule

### sv/rfc32_queue.sv
// two-entry command queue between front and back end
`timescale 1ns / 1ps

module rfc32_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  rfc32_pkg::t_cmd      i_cmd,
    input  logic                 i_pop,
    output rfc32_pkg::t_cmd      o_cmd,
    output rfc32_pkg::t_q_status o_status
);
    import rfc32_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_cmd          = r_mem[r_rp];
    assign o_status.full  = (r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QUEUE_AW'(1);
            end
            r_cnt <= r_cnt + (QUEUE_AW + 1)'(i_push) - (QUEUE_AW + 1)'(i_pop);
        end
    end

endmodule

### sv/rfc32_back.sv
// back end: byte serialiser, crc engine and output register
`timescale 1ns / 1ps

module rfc32_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rfc32_pkg::t_cmd      i_cmd,
    input  rfc32_pkg::t_q_status i_q_status,
    output logic                 o_pop,
    rfc32_out_if.source          o_out
);
    import rfc32_pkg::*;

    localparam logic [1:0] PH_LEN  = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_CRC  = 2'd2;

    logic                  r_act,   n_act;
    logic [1:0]            r_phase, n_phase;
    logic [5:0]            r_left,  n_left;
    logic [FRAME_BITS-1:0] r_shift, n_shift;
    logic [31:0]           r_crc,   n_crc;
    logic                  r_go_crc, n_go_crc;
    logic                  r_ov,    n_ov;
    t_out_item             r_out,   n_out;

    logic        w_can_adv;
    logic        w_step;
    logic        w_at_end;
    logic        w_run_end;
    logic        w_fin;
    logic [31:0] w_crc_body;
    t_out_item   w_item;

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    always_comb begin
        w_can_adv  = !r_ov || o_out.ready;
        w_step     = r_act && w_can_adv;
        w_at_end   = (r_left == 6'd1);
        w_crc_body = crc_byte(r_crc, r_shift[7:0]);
        w_run_end  = w_at_end && ((r_phase == PH_CRC) || ((r_phase == PH_BODY) && !r_go_crc));
        w_fin      = w_step && w_run_end;
        o_pop      = !i_q_status.empty && (!r_act || w_fin);

        w_item.out_byte    = r_shift[7:0];
        w_item.last_of_run = w_run_end;
        w_item.record_end  = w_at_end && (r_phase == PH_CRC);

        n_act    = r_act;
        n_phase  = r_phase;
        n_left   = r_left;
        n_shift  = r_shift;
        n_crc    = r_crc;
        n_go_crc = r_go_crc;
        n_ov     = r_ov;
        n_out    = r_out;

        if (w_step) begin
            n_shift = r_shift >> 8;
            n_left  = r_left - 6'd1;
            unique case (r_phase)
                PH_LEN: begin
                    if (w_at_end) begin
                        n_phase = PH_BODY;
                        n_left  = 6'(HEADER_BYTES);
                    end
                end
                PH_BODY: begin
                    n_crc = w_crc_body;
                    if (w_at_end) begin
                        if (r_go_crc) begin
                            n_phase = PH_CRC;
                            n_left  = 6'(CRC_BYTES);
                            n_shift = {{(FRAME_BITS - 32){1'b0}}, ~w_crc_body};
                        end else begin
                            n_act = 1'b0;
                        end
                    end
                end
                PH_CRC: begin
                    if (w_at_end) begin
                        n_act = 1'b0;
                        n_crc = CRC_ONES;
                    end
                end
                default: begin
                    n_act = 1'b0;
                end
            endcase
        end

        if (o_pop) begin
            n_act    = 1'b1;
            n_shift  = i_cmd.frame;
            n_go_crc = i_cmd.go_crc;
            if (i_cmd.is_start) begin
                n_phase = PH_LEN;
                n_left  = 6'(LEN_BYTES);
                n_crc   = CRC_ONES;
            end else begin
                n_phase = PH_BODY;
                n_left  = 6'd1;
            end
        end

        if (w_can_adv) begin
            n_ov  = w_step;
            n_out = w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_phase  <= PH_LEN;
            r_left   <= '0;
            r_crc    <= CRC_ONES;
            r_go_crc <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_act    <= n_act;
            r_phase  <= n_phase;
            r_left   <= n_left;
            r_crc    <= n_crc;
            r_go_crc <= n_go_crc;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_out   <= n_out;
    end

endmodule

### sv/record_framer_crc32.sv
// top level: length-prefixed record framer with crc-32 trailer
// output: one byte per cycle unless o_out.ready is low, via queue, shift and output registers
// a start transaction gives 48 bytes (52 with an empty payload), a payload byte 1 (5 if last)
// payload transactions are taken one per cycle while the two-entry command queue has room;
// start transactions hold the input via its back pressure while the serialiser walks the header
// synchronous active-low reset: no record open, queue empty, crc all ones, output idle
`timescale 1ns / 1ps
`include "record_framer_crc32_macros.svh"

module record_framer_crc32 #(
    parameter int LENGTH_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rfc32_in_if.sink     i_in,
    rfc32_out_if.source  o_out
);
    import rfc32_pkg::*;

    logic      w_push;
    logic      w_pop;
    t_cmd      w_cmd_in;
    t_cmd      w_cmd_out;
    t_q_status w_q_status;

    rfc32_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in)
    );

    rfc32_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_cmd_in),
        .i_pop    (w_pop),
        .o_cmd    (w_cmd_out),
        .o_status (w_q_status)
    );

    rfc32_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd_out),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_out      (o_out)
    );

    `RFC32_ASSERT_NEVER(a_no_push_when_full, w_push && w_q_status.full)
    `RFC32_ASSERT_NEVER(a_no_pop_when_empty, w_pop && w_q_status.empty)
    `RFC32_ASSERT_IMP(a_end_is_last, o_out.valid && o_out.data.record_end, o_out.data.last_of_run)

endmodule
